@@ hw/rtl/lsms_pkg.sv @@
// shared constants, widths and command struct for the lidar sector minimum steering block
package lsms_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = 12;
    localparam int RANGE_W     = 16;
    localparam int HEAD_W      = 15;
    localparam int START_W     = 15;
    localparam int STEP_W      = 13;
    localparam int SHIFT_W     = 15;
    localparam int GAIN_W      = 12;
    localparam int ACC_W       = 26;
    localparam int GP_W        = 39;
    localparam int ROT_W       = 13;
    localparam int TGT_W       = 17;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_SHIFT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN = 3'd5;

    // register reset values
    localparam logic [RANGE_W-1:0]        RST_RANGE_MIN  = 16'd100;
    localparam logic [RANGE_W-1:0]        RST_RANGE_MAX  = 16'd30000;
    localparam logic signed [START_W-1:0] RST_START_ANG  = -15'sd12868;
    localparam logic signed [STEP_W-1:0]  RST_ANGLE_STEP = 13'sd7;
    localparam logic signed [SHIFT_W-1:0] RST_HEAD_SHIFT = 15'sd0;
    localparam logic [GAIN_W-1:0]         RST_STEER_GAIN = 12'd256;

    // request kinds carried on tuser
    localparam logic KIND_SAMPLE   = 1'b0;
    localparam logic KIND_SCAN_END = 1'b1;

    // fixed-point angle constants, radians * 4096, and the rounding half for the steering shift
    localparam logic signed [ACC_W-1:0] SECTOR_LOW  = -26'sd3217;
    localparam logic signed [GP_W-1:0]  ROUND_HALF  = 39'sd128;
    localparam logic signed [GP_W-1:0]  STEER_HI    = 39'sd2048;
    localparam logic signed [GP_W-1:0]  STEER_LO    = -39'sd2048;
    localparam logic signed [TGT_W-1:0] PI_Q12      = 17'sd12868;
    localparam logic signed [TGT_W-1:0] NEG_PI_Q12  = -17'sd12868;
    localparam logic signed [TGT_W-1:0] TWO_PI_Q12  = 17'sd25736;

    typedef struct packed {
        logic sample_step;
        logic scan_end;
        logic scale;
        logic load_out;
    } lsms_cmd_t;

endpackage

@@ hw/rtl/lidar_sector_min_steering.sv @@
// top level: lidar right-sector nearest obstacle finder with yaw steering
// range samples are taken one per cycle while s_tready is high and give no result
// an end-of-scan request passes through the scale and final states and then raises m_tvalid
// (step times index, gain multiply, round/clamp/wrap into the output register)
// no request is taken in those states, and the final state waits while a result is still held
// samples keep flowing while a result waits on m_tready; the next end of scan then stalls there
// aresetn is synchronous: config registers return to their defaults and the scan is cleared
module lidar_sector_min_steering (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_range[15:0], current_heading[30:16], zero pad
    input  logic [lsms_pkg::S_DATA_W-1:0]     s_tdata,
    // kind
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // nearest_range[15:0], nearest_index[27:16], target_heading[42:28], zero pad
    output logic [lsms_pkg::M_DATA_W-1:0]     m_tdata
);

    localparam int HEAD_LO = lsms_pkg::RANGE_W;
    localparam int TGT_LO  = lsms_pkg::RANGE_W + lsms_pkg::IDX_W;
    localparam int S_PAD   = lsms_pkg::S_DATA_W - lsms_pkg::RANGE_W - lsms_pkg::HEAD_W;
    localparam int M_PAD   = lsms_pkg::M_DATA_W - TGT_LO - lsms_pkg::HEAD_W;

    lsms_pkg::lsms_cmd_t                cmd;
    logic [lsms_pkg::RANGE_W-1:0]       nearest_range;
    logic [lsms_pkg::IDX_W-1:0]         nearest_index;
    logic signed [lsms_pkg::HEAD_W-1:0] target_heading;

    lsms_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lsms_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .sample_range    (s_tdata[lsms_pkg::RANGE_W-1:0]),
        .current_heading ($signed(s_tdata[HEAD_LO +: lsms_pkg::HEAD_W])),
        .nearest_range   (nearest_range),
        .nearest_index   (nearest_index),
        .target_heading  (target_heading)
    );

    assign m_tdata = {{M_PAD{1'b0}}, target_heading, nearest_index, nearest_range};

    // upper pad bits of s_tdata carry nothing
    logic [S_PAD-1:0] s_pad_unused;
    assign s_pad_unused = s_tdata[lsms_pkg::S_DATA_W-1 -: S_PAD];

endmodule

@@ hw/rtl/lsms_ctrl.sv @@
// controller: request handshake, end-of-scan sequencing and result slot
module lsms_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output lsms_pkg::lsms_cmd_t cmd
);

    typedef enum logic [1:0] {ST_RUN, ST_SCALE, ST_FIN} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;

    always_comb begin
        in_accept       = (state_reg == ST_RUN) && s_tvalid;
        cmd.sample_step = in_accept && (s_tuser == lsms_pkg::KIND_SAMPLE);
        cmd.scan_end    = in_accept && (s_tuser == lsms_pkg::KIND_SCAN_END);
        cmd.scale       = (state_reg == ST_SCALE);
        cmd.load_out    = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (cmd.scan_end) state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_FIN;
            ST_FIN: begin
                if (cmd.load_out) state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_RUN);
    assign m_tvalid = out_valid_reg;

endmodule

@@ hw/rtl/lsms_dp.sv @@
// datapath: config registers, sector minimum tracking and steering arithmetic
module lsms_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lsms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsms_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  lsms_pkg::lsms_cmd_t                 cmd,
    input  logic [lsms_pkg::RANGE_W-1:0]        sample_range,
    input  logic signed [lsms_pkg::HEAD_W-1:0]  current_heading,
    output logic [lsms_pkg::RANGE_W-1:0]        nearest_range,
    output logic [lsms_pkg::IDX_W-1:0]          nearest_index,
    output logic signed [lsms_pkg::HEAD_W-1:0]  target_heading
);

    // configuration
    logic [lsms_pkg::RANGE_W-1:0]        range_min_reg, range_max_reg;
    logic signed [lsms_pkg::START_W-1:0] start_reg;
    logic signed [lsms_pkg::STEP_W-1:0]  step_reg;
    logic signed [lsms_pkg::SHIFT_W-1:0] shift_reg;
    logic [lsms_pkg::GAIN_W-1:0]         gain_reg;

    // scan state
    logic [lsms_pkg::CNT_W-1:0]          cnt_reg;
    logic signed [lsms_pkg::ACC_W-1:0]   run_ang_reg;
    logic [lsms_pkg::RANGE_W-1:0]        best_range_reg;
    logic [lsms_pkg::IDX_W-1:0]          best_index_reg;

    // end-of-scan pipeline
    logic signed [lsms_pkg::ACC_W-1:0]   idx_prod_reg;
    logic signed [lsms_pkg::GP_W-1:0]    gain_prod_reg;
    logic signed [lsms_pkg::HEAD_W-1:0]  head_reg;
    logic [lsms_pkg::RANGE_W-1:0]        res_range_reg;
    logic [lsms_pkg::IDX_W-1:0]          res_index_reg;
    logic [lsms_pkg::RANGE_W-1:0]        out_range_reg;
    logic [lsms_pkg::IDX_W-1:0]          out_index_reg;
    logic signed [lsms_pkg::HEAD_W-1:0]  out_head_reg;

    logic                                cnt_zero, cnt_full, hit;
    logic signed [lsms_pkg::ACC_W-1:0]   start_x, step_x, shift_x, ang_cur, idx_x;
    logic signed [lsms_pkg::ACC_W-1:0]   angle_sum;
    logic signed [lsms_pkg::GP_W-1:0]    angle_gx, gain_gx, rsum, rquot;
    logic [lsms_pkg::RANGE_W-1:0]        cur_best;
    logic [lsms_pkg::IDX_W-1:0]          cur_index;
    logic signed [lsms_pkg::ROT_W-1:0]   rot;
    logic signed [lsms_pkg::TGT_W-1:0]   tgt_raw, tgt_wrap;

    always_comb begin
        cnt_zero = (cnt_reg == '0);
        cnt_full = (cnt_reg == lsms_pkg::CNT_W'(lsms_pkg::MAX_SAMPLES));
        start_x  = lsms_pkg::ACC_W'(start_reg);
        step_x   = lsms_pkg::ACC_W'(step_reg);
        shift_x  = lsms_pkg::ACC_W'(shift_reg);

        // a fresh scan starts from the current registers
        ang_cur   = cnt_zero ? start_x : run_ang_reg;
        cur_best  = cnt_zero ? range_max_reg : best_range_reg;
        cur_index = cnt_zero ? '0 : best_index_reg;

        // sign bit set means the beam angle is below zero
        hit = (sample_range >= range_min_reg) && (sample_range <= range_max_reg)
            && (ang_cur > lsms_pkg::SECTOR_LOW) && ang_cur[lsms_pkg::ACC_W-1]
            && (sample_range < cur_best);

        idx_x = lsms_pkg::ACC_W'($signed({1'b0, cur_index}));

        angle_sum = idx_prod_reg + start_x + shift_x;
        angle_gx  = lsms_pkg::GP_W'(angle_sum);
        gain_gx   = lsms_pkg::GP_W'($signed({1'b0, gain_reg}));

        // round half up then clamp to half a radian
        rsum  = gain_prod_reg + lsms_pkg::ROUND_HALF;
        rquot = rsum >>> 8;
        if (rquot > lsms_pkg::STEER_HI) begin
            rot = lsms_pkg::ROT_W'(lsms_pkg::STEER_HI);
        end else if (rquot < lsms_pkg::STEER_LO) begin
            rot = lsms_pkg::ROT_W'(lsms_pkg::STEER_LO);
        end else begin
            rot = rquot[lsms_pkg::ROT_W-1:0];
        end

        tgt_raw = lsms_pkg::TGT_W'(head_reg) - lsms_pkg::TGT_W'(rot);
        // one turn of correction covers every heading code
        if (tgt_raw < lsms_pkg::NEG_PI_Q12) begin
            tgt_wrap = tgt_raw + lsms_pkg::TWO_PI_Q12;
        end else if (tgt_raw > lsms_pkg::PI_Q12) begin
            tgt_wrap = tgt_raw - lsms_pkg::TWO_PI_Q12;
        end else begin
            tgt_wrap = tgt_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg <= lsms_pkg::RST_RANGE_MIN;
            range_max_reg <= lsms_pkg::RST_RANGE_MAX;
            start_reg     <= lsms_pkg::RST_START_ANG;
            step_reg      <= lsms_pkg::RST_ANGLE_STEP;
            shift_reg     <= lsms_pkg::RST_HEAD_SHIFT;
            gain_reg      <= lsms_pkg::RST_STEER_GAIN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lsms_pkg::REG_RANGE_MIN:  range_min_reg <= cfg_wr_data;
                lsms_pkg::REG_RANGE_MAX:  range_max_reg <= cfg_wr_data;
                lsms_pkg::REG_START_ANG:  start_reg <= cfg_wr_data[lsms_pkg::START_W-1:0];
                lsms_pkg::REG_ANGLE_STEP: step_reg  <= cfg_wr_data[lsms_pkg::STEP_W-1:0];
                lsms_pkg::REG_HEAD_SHIFT: shift_reg <= cfg_wr_data[lsms_pkg::SHIFT_W-1:0];
                lsms_pkg::REG_STEER_GAIN: gain_reg  <= cfg_wr_data[lsms_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.scan_end) begin
            cnt_reg <= '0;
        end else if (cmd.sample_step && !cnt_full) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sample_step && !cnt_full) begin
            run_ang_reg    <= ang_cur + step_x;
            best_range_reg <= hit ? sample_range : cur_best;
            best_index_reg <= hit ? cnt_reg[lsms_pkg::IDX_W-1:0] : cur_index;
        end
        if (cmd.scan_end) begin
            res_range_reg <= cur_best;
            res_index_reg <= cur_index;
            head_reg      <= current_heading;
            idx_prod_reg  <= step_x * idx_x;
        end
        if (cmd.scale) begin
            gain_prod_reg <= gain_gx * angle_gx;
        end
        if (cmd.load_out) begin
            out_range_reg <= res_range_reg;
            out_index_reg <= res_index_reg;
            out_head_reg  <= tgt_wrap[lsms_pkg::HEAD_W-1:0];
        end
    end

    assign nearest_range  = out_range_reg;
    assign nearest_index  = out_index_reg;
    assign target_heading = out_head_reg;

endmodule

@@ hw/rtl/lsms_checker.sv @@
// port-level checker for the lidar sector minimum steering block, with its bind
module lsms_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lsms_pkg::M_DATA_W-1:0] m_tdata
);

    logic eos_accept;
    assign eos_accept = s_tvalid && s_tready && (s_tuser == lsms_pkg::KIND_SCAN_END);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // end of scan busies the input side while the steering math runs
    a_eos_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        eos_accept |=> !s_tready)
        else $error("request taken during steering computation");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        eos_accept && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    a_heading_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[42:28]) >= -15'sd12868)
                  && ($signed(m_tdata[42:28]) <= 15'sd12868))
        else $error("target heading outside +-pi");

endmodule

bind lidar_sector_min_steering lsms_checker u_lsms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_lidar_sector_min_steering.sv @@
// self-checking testbench for the lidar sector minimum steering block
module tb_lidar_sector_min_steering;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lsms_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [lsms_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct {
        logic [lsms_pkg::RANGE_W-1:0]        rng;
        logic [lsms_pkg::IDX_W-1:0]          idx;
        logic signed [lsms_pkg::HEAD_W-1:0]  hdg;
    } scan_result_t;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                cfg_wr_en   = 1'b0;
    logic [lsms_pkg::CFG_IDX_W-1:0]      cfg_index   = '0;
    logic [lsms_pkg::CFG_DATA_W-1:0]     cfg_wr_data = '0;
    logic                                s_tvalid    = 1'b0;
    logic                                s_tready;
    logic [lsms_pkg::S_DATA_W-1:0]       s_tdata     = '0;
    logic                                s_tuser     = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready    = 1'b0;
    logic [lsms_pkg::M_DATA_W-1:0]       m_tdata;

    // predictor copy of the registers
    logic [lsms_pkg::RANGE_W-1:0]        win_lo     = lsms_pkg::RST_RANGE_MIN;
    logic [lsms_pkg::RANGE_W-1:0]        win_hi     = lsms_pkg::RST_RANGE_MAX;
    logic signed [lsms_pkg::START_W-1:0] start_ang  = lsms_pkg::RST_START_ANG;
    logic signed [lsms_pkg::STEP_W-1:0]  ang_step   = lsms_pkg::RST_ANGLE_STEP;
    logic signed [lsms_pkg::SHIFT_W-1:0] head_shift = lsms_pkg::RST_HEAD_SHIFT;
    logic [lsms_pkg::GAIN_W-1:0]         gain_q48   = lsms_pkg::RST_STEER_GAIN;

    // predictor copy of the scan state
    int                            scan_len = 0;
    int                            beam_ang = 0;
    logic [lsms_pkg::RANGE_W-1:0]  near_rng = '0;
    logic [lsms_pkg::IDX_W-1:0]    near_idx = '0;

    scan_result_t scan_results_due[$];
    scan_result_t due;

    int  fail_count  = 0;
    int  sent_items  = 0;
    int  hold_left   = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;
    logic [lsms_pkg::RANGE_W-1:0] last_range = '0;

    lidar_sector_min_steering DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("tb_lidar_sector_min_steering NOT OK");
        $finish;
    end

    task automatic note_fail(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void take_sample(input logic [lsms_pkg::RANGE_W-1:0] r);
        if (scan_len >= lsms_pkg::MAX_SAMPLES) return;
        // first sample of a scan picks up the registers as they are now
        if (scan_len == 0) begin
            beam_ang = start_ang;
            near_rng = win_hi;
            near_idx = '0;
        end
        if (r >= win_lo && r <= win_hi && beam_ang > lsms_pkg::SECTOR_LOW && beam_ang < 0
                && r < near_rng) begin
            near_rng = r;
            near_idx = scan_len[lsms_pkg::IDX_W-1:0];
        end
        beam_ang += ang_step;
        scan_len++;
    endfunction

    function automatic void close_scan(input logic signed [lsms_pkg::HEAD_W-1:0] hdg);
        scan_result_t res;
        longint angle, rot, tgt;
        res.rng = near_rng;
        res.idx = near_idx;
        if (scan_len == 0) begin
            res.rng = win_hi;
            res.idx = '0;
        end
        angle = longint'(start_ang) + longint'(ang_step) * longint'(res.idx)
                + longint'(head_shift);
        // Q.20 back to Q.12, round half up
        rot = (longint'(gain_q48) * angle + lsms_pkg::ROUND_HALF) >>> 8;
        if (rot > lsms_pkg::STEER_HI) rot = lsms_pkg::STEER_HI;
        if (rot < lsms_pkg::STEER_LO) rot = lsms_pkg::STEER_LO;
        tgt = longint'(hdg) - rot;
        while (tgt < lsms_pkg::NEG_PI_Q12) tgt += lsms_pkg::TWO_PI_Q12;
        while (tgt > lsms_pkg::PI_Q12) tgt -= lsms_pkg::TWO_PI_Q12;
        res.hdg = tgt[lsms_pkg::HEAD_W-1:0];
        scan_results_due.push_back(res);
        scan_len = 0;
    endfunction

    task automatic send_req(input logic kind, input logic [lsms_pkg::RANGE_W-1:0] rng,
                            input logic signed [lsms_pkg::HEAD_W-1:0] hdg);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, hdg, rng};
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        if (kind == lsms_pkg::KIND_SAMPLE) take_sample(rng);
        else close_scan(hdg);
    endtask

    task automatic put_sample(input int unsigned r);
        last_range = r[lsms_pkg::RANGE_W-1:0];
        send_req(lsms_pkg::KIND_SAMPLE, r[lsms_pkg::RANGE_W-1:0],
                 lsms_pkg::HEAD_W'($urandom));
    endtask

    task automatic put_scan_end(input int hdg);
        send_req(lsms_pkg::KIND_SCAN_END, lsms_pkg::RANGE_W'($urandom),
                 lsms_pkg::HEAD_W'(hdg));
    endtask

    task automatic put_scan(input int unsigned ranges[$], input int hdg);
        foreach (ranges[i]) put_sample(ranges[i]);
        put_scan_end(hdg);
    endtask

    // block must be idle here: nothing owed and no sample still in flight
    task automatic write_reg(input logic [lsms_pkg::CFG_IDX_W-1:0] idx, input int value);
        logic [lsms_pkg::CFG_DATA_W-1:0] data;
        data = lsms_pkg::CFG_DATA_W'(value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            lsms_pkg::REG_RANGE_MIN:  win_lo     = data;
            lsms_pkg::REG_RANGE_MAX:  win_hi     = data;
            lsms_pkg::REG_START_ANG:  start_ang  = data[lsms_pkg::START_W-1:0];
            lsms_pkg::REG_ANGLE_STEP: ang_step   = data[lsms_pkg::STEP_W-1:0];
            lsms_pkg::REG_HEAD_SHIFT: head_shift = data[lsms_pkg::SHIFT_W-1:0];
            lsms_pkg::REG_STEER_GAIN: gain_q48   = data[lsms_pkg::GAIN_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (scan_results_due.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
    endtask

    // random upper bits above the register width must be dropped
    function automatic int with_junk(input int v, input int w);
        logic [lsms_pkg::CFG_DATA_W-1:0] m;
        m = 16'hFFFF >> (lsms_pkg::CFG_DATA_W - w);
        return (lsms_pkg::CFG_DATA_W'(v) & m) | (lsms_pkg::CFG_DATA_W'($urandom) & ~m);
    endfunction

    function automatic logic [lsms_pkg::RANGE_W-1:0] pick_range();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70 && win_lo <= win_hi)
            return lsms_pkg::RANGE_W'($urandom_range(win_hi, win_lo));
        if (p < 80) return last_range;
        if (p < 90) return p[0] ? win_lo : win_hi;
        return lsms_pkg::RANGE_W'($urandom);
    endfunction

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (scan_results_due.size() == 0) begin
                note_fail($sformatf("unexpected result %h", m_tdata));
            end else begin
                due = scan_results_due.pop_front();
                if (m_tdata[15:0] !== due.rng)
                    note_fail($sformatf("nearest_range %0d, want %0d",
                                        m_tdata[15:0], due.rng));
                if (m_tdata[27:16] !== due.idx)
                    note_fail($sformatf("nearest_index %0d, want %0d",
                                        m_tdata[27:16], due.idx));
                if (m_tdata[42:28] !== due.hdg)
                    note_fail($sformatf("target_heading %0d, want %0d",
                                        $signed(m_tdata[42:28]), due.hdg));
            end
        end
    end

    task automatic test_reset_defaults();
        put_scan_end(12868);
        put_scan('{0, 65535, 500, 99, 100}, -12868);
    endtask

    task automatic test_sector_bounds();
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -3218);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 1);
        // first two beams sit on or below -45 deg, equal minima keep the first
        put_scan('{120, 110, 500, 500, 99, 30001, 30000, 100}, 0);
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -20);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 10);
        // third beam lands exactly on 0 and is outside
        put_scan('{400, 300, 200}, 1000);
    endtask

    task automatic test_range_window();
        drain_results();
        write_reg(lsms_pkg::REG_RANGE_MIN, 65535);
        write_reg(lsms_pkg::REG_RANGE_MAX, 0);
        put_scan('{0, 65535, 1000}, -5);
        drain_results();
        write_reg(lsms_pkg::REG_RANGE_MIN, 0);
        write_reg(lsms_pkg::REG_RANGE_MAX, 65535);
        put_scan('{65535, 0, 7}, 5);
    endtask

    task automatic test_steering();
        drain_results();
        write_reg(lsms_pkg::REG_ANGLE_STEP, 0);
        write_reg(lsms_pkg::REG_STEER_GAIN, 1);
        // rounding across the half step, both signs
        write_reg(lsms_pkg::REG_START_ANG, 128);
        put_scan_end(0);
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -128);
        put_scan_end(0);
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -129);
        put_scan_end(0);
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, 16383);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 4095);
        write_reg(lsms_pkg::REG_HEAD_SHIFT, 16383);
        write_reg(lsms_pkg::REG_STEER_GAIN, 4095);
        put_scan_end(-16384);
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -16384);
        write_reg(lsms_pkg::REG_ANGLE_STEP, -4096);
        write_reg(lsms_pkg::REG_HEAD_SHIFT, -16384);
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, 16'hFFFF);
        put_scan('{5000}, 16383);
        drain_results();
        write_reg(lsms_pkg::REG_STEER_GAIN, with_junk(0, lsms_pkg::GAIN_W));
        put_scan_end(16383);
    endtask

    task automatic test_mid_scan_write();
        drain_results();
        write_reg(lsms_pkg::REG_RANGE_MIN, 100);
        write_reg(lsms_pkg::REG_RANGE_MAX, 30000);
        write_reg(lsms_pkg::REG_START_ANG, -100);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 10);
        write_reg(lsms_pkg::REG_HEAD_SHIFT, 0);
        write_reg(lsms_pkg::REG_STEER_GAIN, 256);
        put_sample(500);
        put_sample(400);
        drain_results();
        // step applies from the next sample, start only to the end-of-scan angle
        write_reg(lsms_pkg::REG_ANGLE_STEP, -10);
        write_reg(lsms_pkg::REG_START_ANG, 5000);
        write_reg(lsms_pkg::REG_RANGE_MAX, 300);
        put_scan('{350, 250, 260}, -7000);
    endtask

    task automatic test_sample_limit();
        drain_results();
        write_reg(lsms_pkg::REG_RANGE_MIN, 100);
        write_reg(lsms_pkg::REG_RANGE_MAX, 30000);
        write_reg(lsms_pkg::REG_START_ANG, -3216);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 0);
        quiet = 1'b1;
        for (int i = 0; i < lsms_pkg::MAX_SAMPLES - 1; i++)
            put_sample($urandom_range(200, 30000));
        put_sample(150);
        // beyond the limit: smaller but must be ignored
        repeat (4) put_sample(100);
        put_scan_end($urandom);
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        drain_results();
        write_reg(lsms_pkg::REG_START_ANG, -3000);
        write_reg(lsms_pkg::REG_ANGLE_STEP, 25);
        hold_left = 300;
        repeat (4) begin
            repeat ($urandom_range(3, 12)) put_sample(pick_range());
            put_scan_end($urandom);
        end
        drain_results();
    endtask

    task automatic test_random();
        int target, len, lo, hi;
        target = sent_items + 1450;
        while (sent_items < target) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_results();
                lo = $urandom_range(0, 3000);
                hi = $urandom_range(lo, 40000);
                if ($urandom_range(0, 7) == 0) begin
                    lo = $urandom_range(0, 65535);
                    hi = $urandom_range(0, 65535);
                end
                write_reg(lsms_pkg::REG_RANGE_MIN, lo);
                write_reg(lsms_pkg::REG_RANGE_MAX, hi);
                write_reg(lsms_pkg::REG_START_ANG, with_junk(($urandom_range(0, 7) == 0) ?
                          $urandom : $urandom_range(0, 3700) - 3500, lsms_pkg::START_W));
                write_reg(lsms_pkg::REG_ANGLE_STEP, with_junk(($urandom_range(0, 7) == 0) ?
                          $urandom : $urandom_range(0, 160) - 80, lsms_pkg::STEP_W));
                write_reg(lsms_pkg::REG_HEAD_SHIFT, with_junk(($urandom_range(0, 3) == 0) ?
                          $urandom : $urandom_range(0, 2000) - 1000, lsms_pkg::SHIFT_W));
                write_reg(lsms_pkg::REG_STEER_GAIN, with_junk($urandom, lsms_pkg::GAIN_W));
                if ($urandom_range(0, 5) == 0)
                    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
            end
            quiet = ($urandom_range(0, 9) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(31, 120) : $urandom_range(0, 30);
            repeat (len) put_sample(pick_range());
            put_scan_end($urandom);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_sector_bounds();
        test_range_window();
        test_steering();
        test_mid_scan_write();
        test_sample_limit();
        test_backpressure();
        test_random();
        drain_results();
        if (scan_results_due.size() != 0)
            note_fail($sformatf("%0d results never came", scan_results_due.size()));
        if (fail_count == 0) begin
            $display("tb_lidar_sector_min_steering OK");
        end else begin
            $display("tb_lidar_sector_min_steering NOT OK");
        end
        $finish;
    end

endmodule
